FILE: hdl/magnet_hold_gesture_fsm_unit_assert.svh
// assertion macros shared by the magnet-hold gesture rtl
// no dependencies; clk_i and rst_ni must exist in the including module
`ifndef MAGNET_HOLD_GESTURE_FSM_UNIT_ASSERT_SVH
`define MAGNET_HOLD_GESTURE_FSM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked while out of reset
`define MHG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mhg assertion failed");
// property checked on every edge, reset included
`define MHG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mhg assertion failed");
`else
`define MHG_ASSERT(label, prop)
`define MHG_ASSERT_ALWAYS(label, prop)
`endif

`endif

FILE: hdl/mhg_pkg.sv
// types, codes and reset constants for the magnet-hold gesture recognizer
// no dependencies
package mhg_pkg;

  // configuration register file
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_PAIR_HOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DFU_ENTER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_GAP  = 2'd2;

  localparam logic [CfgDataW-1:0] PAIR_HOLD_RST = 16'd3000;
  localparam logic [CfgDataW-1:0] DFU_ENTER_RST = 16'd10000;
  localparam logic [CfgDataW-1:0] HOLD_GAP_RST  = 16'd500;

  localparam int unsigned TimeW = 32;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_HOLDING  = 2'd1,
    PH_HOLD_MET = 2'd2,
    PH_COOLDOWN = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    LED_NONE = 2'd0,
    LED_ON   = 2'd1,
    LED_OFF  = 2'd2
  } led_e;

  typedef struct packed {
    logic [CfgDataW-1:0] pair_hold_ms;
    logic [CfgDataW-1:0] dfu_enter_ms;
    logic [CfgDataW-1:0] hold_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic             magnet_active;
    logic [TimeW-1:0] now_ms;
    logic             update_mode;
  } in_item_t;

  typedef struct packed {
    phase_e phase;
    logic   pair_toggle;
    logic   update_enter;
    logic   update_exit;
    led_e   led_cmd;
  } out_item_t;

endpackage

FILE: hdl/mhg_cfg.sv
// configuration registers: hold limits written through a plain write port
// depends on mhg_pkg
module mhg_cfg import mhg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the write, unknown index is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAIR_HOLD: cfg_d.pair_hold_ms = cfg_wdata_i;
        CFG_DFU_ENTER: cfg_d.dfu_enter_ms = cfg_wdata_i;
        CFG_HOLD_GAP:  cfg_d.hold_gap_ms  = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pair_hold_ms <= PAIR_HOLD_RST;
      cfg_q.dfu_enter_ms <= DFU_ENTER_RST;
      cfg_q.hold_gap_ms  <= HOLD_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/mhg_core.sv
// gesture state machine: one poll per step, result produced combinationally
// depends on mhg_pkg and the assertion macro header
`include "magnet_hold_gesture_fsm_unit_assert.svh"

module mhg_core import mhg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  phase_e           phase_q, phase_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] origin_q, origin_d;
  logic             orig_vld_q, orig_vld_d;
  logic             must_rel_q, must_rel_d;
  logic             prev_upd_q, prev_upd_d;

  logic             active;
  logic             upd;
  logic             entry;
  phase_e           ph_e;
  logic             orig_vld_e;
  logic             must_rel_e;
  logic [TimeW-1:0] start_diff;
  logic [TimeW-1:0] origin_diff;
  logic             pair_met;
  logic             gap_met;
  logic             long_hit;

  assign active = item_i.magnet_active;
  assign upd    = item_i.update_mode;

  // entering update mode restarts from idle with the origin dropped
  assign entry      = upd && !prev_upd_q;
  assign ph_e       = entry ? PH_IDLE : phase_q;
  assign orig_vld_e = entry ? 1'b0 : orig_vld_q;
  assign must_rel_e = entry ? active : must_rel_q;

  // elapsed time checks, differences wrap mod 2^32
  assign start_diff  = item_i.now_ms - start_q;
  assign origin_diff = item_i.now_ms - origin_q;
  assign pair_met    = start_diff  >= {{(TimeW-CfgDataW){1'b0}}, cfg_i.pair_hold_ms};
  assign gap_met     = start_diff  >= {{(TimeW-CfgDataW){1'b0}}, cfg_i.hold_gap_ms};
  assign long_hit    = orig_vld_e &&
                       (origin_diff >= {{(TimeW-CfgDataW){1'b0}}, cfg_i.dfu_enter_ms});

  // next state
  always_comb begin
    phase_d    = ph_e;
    start_d    = start_q;
    origin_d   = origin_q;
    orig_vld_d = orig_vld_e;
    must_rel_d = must_rel_e;
    prev_upd_d = upd;
    if (upd) begin
      unique case (ph_e)
        PH_IDLE: begin
          if (must_rel_e) begin
            if (!active) must_rel_d = 1'b0;
          end else if (active) begin
            phase_d    = PH_HOLDING;
            start_d    = item_i.now_ms;
            origin_d   = item_i.now_ms;
            orig_vld_d = 1'b1;
          end
        end
        PH_HOLDING: begin
          if (!active) begin
            phase_d    = PH_IDLE;
            orig_vld_d = 1'b0;
          end else if (pair_met) begin
            phase_d = PH_HOLD_MET;
            start_d = item_i.now_ms;
          end
        end
        PH_HOLD_MET: begin
          if (gap_met) phase_d = PH_COOLDOWN;
        end
        PH_COOLDOWN: begin
          if (!active) begin
            phase_d    = PH_IDLE;
            orig_vld_d = 1'b0;
          end
        end
        default: phase_d = ph_e;
      endcase
    end else begin
      priority if (ph_e == PH_IDLE) begin
        if (active) begin
          phase_d    = PH_HOLDING;
          start_d    = item_i.now_ms;
          origin_d   = item_i.now_ms;
          orig_vld_d = 1'b1;
        end
      end else if ((ph_e == PH_HOLDING) && !active) begin
        phase_d    = PH_IDLE;
        orig_vld_d = 1'b0;
      end else if (active && long_hit) begin
        phase_d    = PH_IDLE;
        orig_vld_d = 1'b0;
      end else if (ph_e == PH_HOLDING) begin
        if (pair_met) begin
          phase_d = PH_HOLD_MET;
          start_d = item_i.now_ms;
        end
      end else if (ph_e == PH_HOLD_MET) begin
        if (gap_met) phase_d = PH_COOLDOWN;
      end else begin
        if (!active) begin
          phase_d    = PH_IDLE;
          orig_vld_d = 1'b0;
        end
      end
    end
  end

  // result of the step
  always_comb begin
    res_o              = '0;
    res_o.phase        = phase_d;
    res_o.pair_toggle  = 1'b0;
    res_o.update_enter = 1'b0;
    res_o.update_exit  = 1'b0;
    res_o.led_cmd      = LED_NONE;
    if (upd) begin
      res_o.update_exit = (ph_e == PH_COOLDOWN) && !active;
    end else begin
      priority if (ph_e == PH_IDLE) begin
        if (active) res_o.led_cmd = LED_ON;
      end else if ((ph_e == PH_HOLDING) && !active) begin
        res_o.led_cmd = LED_OFF;
      end else if (active && long_hit) begin
        res_o.update_enter = 1'b1;
        res_o.led_cmd      = LED_ON;
      end else if (ph_e == PH_HOLDING) begin
        if (pair_met) res_o.led_cmd = LED_OFF;
      end else if (ph_e == PH_HOLD_MET) begin
        res_o.led_cmd = LED_NONE;
      end else begin
        // release in cooldown toggles pairing unless the long hold was reached
        res_o.pair_toggle = !active && !long_hit;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      orig_vld_q <= 1'b0;
      must_rel_q <= 1'b0;
      prev_upd_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      orig_vld_q <= orig_vld_d;
      must_rel_q <= must_rel_d;
      prev_upd_q <= prev_upd_d;
    end
  end

  // timestamps, only read while the origin is valid
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      start_q  <= start_d;
      origin_q <= origin_d;
    end
  end

  `MHG_ASSERT(a_origin_tracks_phase, orig_vld_q == (phase_q != PH_IDLE))
  `MHG_ASSERT(a_no_led_in_update, (step_i && upd) |-> (res_o.led_cmd == LED_NONE))
  `MHG_ASSERT(a_enter_goes_idle, (step_i && res_o.update_enter) |=> (phase_q == PH_IDLE))

endmodule

FILE: hdl/magnet_hold_gesture_fsm_unit.sv
// top level of the magnet-hold gesture recognizer: input and result registers
// depends on mhg_pkg, mhg_cfg, mhg_core and the assertion macro header
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------
//   in      | to block  | in_valid_i / in_stall_o | in_item_t
//   out     | from block| out_valid_o / out_stall_i | out_item_t
//   cfg     | to block  | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// one item per cycle sustained while out_stall_i does not hold the result; an accepted
// item passes the input register, then the state step into the result register
// the state step for an item happens when it moves into the result register
// a stalled result holds the item in the input register; in_stall_o then rises
// reset (async, active low) clears the phase machine and loads default limits
`include "magnet_hold_gesture_fsm_unit_assert.svh"

module magnet_hold_gesture_fsm_unit import mhg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t res;
  logic      out_free;
  logic      advance;
  logic      in_acc;

  mhg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mhg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // flow control between the two registers
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) s1_item_q <= in_item_i;
    if (advance) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `MHG_ASSERT(a_one_pulse, out_valid_o |-> ($countones({out_item_o.pair_toggle,
      out_item_o.update_enter, out_item_o.update_exit}) <= 1))
  `MHG_ASSERT(a_blocked_item_kept, (s1_valid_q && !advance) |=> s1_valid_q)
  `MHG_ASSERT(a_stalled_result_kept,
      (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))

endmodule
